[sv/lfu_cache_table_core_macros.svh]
// assertion macros for the lfu cache table checker
`ifndef LFU_CACHE_TABLE_CORE_MACROS_SVH
`define LFU_CACHE_TABLE_CORE_MACROS_SVH
// assert that a implies b on the next edge
`define LFU_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lfu check failed");
// assert that a implies b on the same edge
`define LFU_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lfu check failed");
`endif

[sv/lfu_pkg.sv]
// package with types and constants of the lfu cache table
`timescale 1ns / 1ps
package lfu_pkg;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CAP_W = 5;
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;
	localparam logic [2:0] ADDR_CAP = 3'd0;

	typedef struct packed {
		logic mode;
		logic signed [KEY_W-1:0] lookup_key;
		logic signed [VAL_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic signed [VAL_W-1:0] read_value;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_UPDATE,
		ST_WRITE,
		ST_RESP
	} state_t;
endpackage

[sv/lfu_if.sv]
// valid/ready channel interfaces of the lfu cache table
`timescale 1ns / 1ps
interface lfu_req_if;
	import lfu_pkg::*;
	logic valid;
	logic ready;
	logic mode;
	logic signed [KEY_W-1:0] lookup_key;
	logic signed [VAL_W-1:0] write_value;
	modport source (output valid, mode, lookup_key, write_value, input ready);
	modport sink (input valid, mode, lookup_key, write_value, output ready);
endinterface

interface lfu_rsp_if;
	import lfu_pkg::*;
	logic valid;
	logic ready;
	logic hit;
	logic signed [VAL_W-1:0] read_value;
	modport source (output valid, hit, read_value, input ready);
	modport sink (input valid, hit, read_value, output ready);
endinterface

[sv/lfu_cache_table_core.sv]
// top level of the lfu cache table with lru tie break
`timescale 1ns / 1ps
// one request at a time: the next request is accepted only after the response is taken
// the entry memory has one read port, so the key and victim scan reads one entry per cycle
// the scan is followed by a decision state and a rank rewrite pass over all entries
// reset clears valid bits, occupancy and control; capacity resets to 16
module lfu_cache_table_core #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	lfu_req_if.sink req,
	lfu_rsp_if.source rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lfu_pkg::*;
	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned W = KEY_W + VAL_W + COUNT_BITS + AW;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	state_t state_q, state_d;
	logic [CAP_W-1:0] cap;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0] occ_q;
	req_t req_q;
	rsp_t rsp_q;
	// scan pointers: address issued, address of data returning
	logic [CW-1:0] ptr_q;
	logic [AW-1:0] rptr_q;
	logic rd_vld_q;
	logic hit_q;
	logic [AW-1:0] hit_idx_q;
	logic [AW-1:0] hit_rank_q;
	logic [VAL_W-1:0] hit_val_q;
	logic vic_vld_q;
	logic [AW-1:0] vic_idx_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [AW-1:0] vic_rank_q;
	logic free_vld_q;
	logic [AW-1:0] free_idx_q;
	// decided action for the rank pass
	logic do_touch_q, do_ins_q, do_evict_q;
	logic [AW-1:0] tgt_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [W-1:0] wdata, rdata;
	logic [KEY_W-1:0] r_key;
	logic [VAL_W-1:0] r_val;
	logic [COUNT_BITS-1:0] r_cnt;
	logic [AW-1:0] r_rank;
	logic [CW-1:0] cap_eff;

	lfu_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cap
	);

	lfu_mem #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS), .AW(AW)) u_mem (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign {r_key, r_val, r_cnt, r_rank} = rdata;
	assign cap_eff = (32'(cap) > ENTRIES) ? CW'(ENTRIES) : CW'(cap);
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_RESP);
	assign rsp.hit = rsp_q.hit;
	assign rsp.read_value = rsp_q.read_value;
	assign raddr = ptr_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (req.valid) state_d = ST_SCAN;
			ST_SCAN:   if (ptr_q == CW'(ENTRIES - 1)) state_d = ST_WAIT;
			ST_WAIT:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_WRITE;
			ST_WRITE:  if (!rd_vld_q && ptr_q == CW'(ENTRIES)) state_d = ST_RESP;
			ST_RESP:   if (rsp.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// rank pass: read each entry, write back adjusted rank; target entry handled too
	logic [AW-1:0] new_rank;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [VAL_W-1:0] new_val;
	logic [KEY_W-1:0] new_key;
	logic wr_ent;
	always_comb begin
		new_rank = r_rank;
		new_cnt = r_cnt;
		new_val = r_val;
		new_key = r_key;
		wr_ent = 1'b0;
		if (state_q == ST_WRITE && rd_vld_q) begin
			if (do_touch_q) begin
				if (rptr_q == tgt_q) begin
					new_rank = '0;
					new_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
					if (req_q.mode == MODE_PUT) new_val = req_q.write_value;
					wr_ent = 1'b1;
				end else if (valid_q[rptr_q] && r_rank < hit_rank_q) begin
					new_rank = r_rank + 1'b1;
					wr_ent = 1'b1;
				end
			end else if (do_ins_q) begin
				if (rptr_q == tgt_q) begin
					new_rank = '0;
					new_cnt = COUNT_BITS'(1);
					new_val = req_q.write_value;
					new_key = req_q.lookup_key;
					wr_ent = 1'b1;
				end else if (valid_q[rptr_q]) begin
					// evicted entry's followers shift up, then all shift down
					if (do_evict_q && r_rank > vic_rank_q) new_rank = r_rank;
					else new_rank = r_rank + 1'b1;
					wr_ent = 1'b1;
				end
			end
		end
	end
	assign we = wr_ent;
	assign waddr = rptr_q;
	assign wdata = {new_key, new_val, new_cnt, new_rank};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q <= '0;
			ptr_q <= '0;
			rd_vld_q <= 1'b0;
			do_touch_q <= 1'b0;
			do_ins_q <= 1'b0;
			do_evict_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ptr_q <= '0;
					rd_vld_q <= 1'b0;
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					rd_vld_q <= 1'b1;
				end
				ST_WAIT: begin
					ptr_q <= '0;
					rd_vld_q <= 1'b0;
				end
				ST_UPDATE: begin
					do_touch_q <= 1'b0;
					do_ins_q <= 1'b0;
					do_evict_q <= 1'b0;
					if (hit_q) begin
						do_touch_q <= (req_q.mode == MODE_GET) || (cap_eff != '0);
					end else if (req_q.mode == MODE_PUT && cap_eff != '0) begin
						if (occ_q >= cap_eff && vic_vld_q) begin
							do_ins_q <= 1'b1;
							do_evict_q <= 1'b1;
							valid_q[vic_idx_q] <= 1'b1;
						end else if (free_vld_q) begin
							do_ins_q <= 1'b1;
							valid_q[free_idx_q] <= 1'b1;
							occ_q <= occ_q + 1'b1;
						end
					end
					ptr_q <= ptr_q + 1'b1;
					rd_vld_q <= 1'b1;
				end
				ST_WRITE: begin
					if (ptr_q != CW'(ENTRIES)) begin
						ptr_q <= ptr_q + 1'b1;
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
					end
				end
				ST_RESP: ;
				default: ;
			endcase
		end
	end

	// scan trackers and request capture
	always_ff @(posedge clk) begin
		rptr_q <= raddr;
		if (state_q == ST_IDLE) begin
			req_q.mode <= req.mode;
			req_q.lookup_key <= req.lookup_key;
			req_q.write_value <= req.write_value;
			hit_q <= 1'b0;
			vic_vld_q <= 1'b0;
			free_vld_q <= 1'b0;
		end
		if ((state_q == ST_SCAN || state_q == ST_WAIT) && rd_vld_q) begin
			if (valid_q[rptr_q]) begin
				if (r_key == req_q.lookup_key) begin
					hit_q <= 1'b1;
					hit_idx_q <= rptr_q;
					hit_rank_q <= r_rank;
					hit_val_q <= r_val;
				end
				if (!vic_vld_q || r_cnt < vic_cnt_q
						|| (r_cnt == vic_cnt_q && r_rank > vic_rank_q)) begin
					vic_vld_q <= 1'b1;
					vic_idx_q <= rptr_q;
					vic_cnt_q <= r_cnt;
					vic_rank_q <= r_rank;
				end
			end else if (!free_vld_q) begin
				free_vld_q <= 1'b1;
				free_idx_q <= rptr_q;
			end
		end
		if (state_q == ST_UPDATE) begin
			tgt_q <= hit_q ? hit_idx_q
				: ((occ_q >= cap_eff && vic_vld_q) ? vic_idx_q : free_idx_q);
			rsp_q.hit <= hit_q && !(req_q.mode == MODE_PUT && cap_eff == '0);
			if (req_q.mode == MODE_GET) begin
				rsp_q.read_value <= hit_q ? hit_val_q : MISS_VALUE;
			end else begin
				rsp_q.read_value <= '0;
			end
		end
	end
endmodule

[sv/lfu_mem.sv]
// entry memory: key, value, count and rank, one synchronous read port
`timescale 1ns / 1ps
module lfu_mem #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned COUNT_BITS = 16,
	parameter int unsigned AW = 4
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [lfu_pkg::KEY_W+lfu_pkg::VAL_W+COUNT_BITS+AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [lfu_pkg::KEY_W+lfu_pkg::VAL_W+COUNT_BITS+AW-1:0] rdata
);
	import lfu_pkg::*;
	localparam int unsigned W = KEY_W + VAL_W + COUNT_BITS + AW;
	logic [W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/lfu_cfg.sv]
// apb configuration register for the capacity
`timescale 1ns / 1ps
module lfu_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [lfu_pkg::CAP_W-1:0] cap
);
	import lfu_pkg::*;
	logic [CAP_W-1:0] cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(16);
		end else if (psel && penable && pwrite && paddr == ADDR_CAP) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_CAP) ? {{(32-CAP_W){1'b0}}, cap_q} : 32'd0;
	assign cap = cap_q;
endmodule

[sv/lfu_checker.sv]
// port level checker for the lfu cache table, bound to the top level
`timescale 1ns / 1ps
`include "lfu_cache_table_core_macros.svh"
module lfu_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_hit,
	input logic [31:0] rsp_read_value,
	input logic pready
);
	`LFU_ASSERT_NOW(a_no_overlap, clk, arst_n, rsp_valid, !req_ready)
	`LFU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	`LFU_ASSERT_NEXT(a_rsp_held, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_hit))
	`LFU_ASSERT_NOW(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind lfu_cache_table_core lfu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.hit),
	.rsp_read_value(rsp.read_value), .pready(pready)
);
